// File: hw/rtl/tis_pkg.sv
package tis_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RATIO_BITS_DEFAULT = 16;
    localparam int NUM_VERTICES = 3;

    localparam logic [1:0] VERTEX_0 = 2'd0;
    localparam logic [1:0] VERTEX_1 = 2'd1;
    localparam logic [1:0] VERTEX_2 = 2'd2;

    // indexed by the above-level code, bit k set when value_k > iso_level
    localparam logic [7:0] CROSSES_TAB = 8'b0111_1110;
    localparam logic [7:0][1:0] APEX_TAB = {
        VERTEX_0, VERTEX_0, VERTEX_1, VERTEX_2, VERTEX_2, VERTEX_1, VERTEX_0, VERTEX_0
    };

    typedef logic [VALUE_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t value_0;
        word_t value_1;
        word_t value_2;
        word_t x_0;
        word_t y_0;
        word_t z_0;
        word_t x_1;
        word_t y_1;
        word_t z_1;
        word_t x_2;
        word_t y_2;
        word_t z_2;
    } tis_in_t;

    typedef struct packed {
        logic       segment_present;
        logic [1:0] apex_vertex;
        word_t      start_x;
        word_t      start_y;
        word_t      start_z;
        word_t      end_x;
        word_t      end_y;
        word_t      end_z;
    } tis_out_t;

    // geometry carried alongside the ratio division
    typedef struct packed {
        logic             present;
        logic [1:0]       apex;
        logic [2:0][VALUE_WIDTH-1:0] pa;
        logic [2:0][VALUE_WIDTH-1:0] mag_b;
        logic [2:0]       dir_b;
        logic [2:0][VALUE_WIDTH-1:0] mag_c;
        logic [2:0]       dir_c;
    } tis_geo_t;

    function automatic word_t abs_diff(input word_t a, input word_t b);
        word_t res;
        if ($signed(a) > $signed(b))
        begin
            res = a - b;
        end
        else
        begin
            res = b - a;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/tis_classify.sv
module tis_classify #(
    parameter int RATIO_BITS = tis_pkg::RATIO_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid,
    input  tis_pkg::tis_in_t      item,
    input  tis_pkg::word_t        iso_level,
    output logic                  valid_reg,
    output tis_pkg::tis_geo_t     geo_reg,
    output tis_pkg::word_t        r0_reg,
    output tis_pkg::word_t        d0_reg,
    output logic [RATIO_BITS:0]   q0_reg,
    output tis_pkg::word_t        r1_reg,
    output tis_pkg::word_t        d1_reg,
    output logic [RATIO_BITS:0]   q1_reg
);

    tis_pkg::word_t    val [3];
    tis_pkg::word_t    pos [3][3];
    logic [2:0]        code;
    logic [1:0]        a, b, c;
    tis_pkg::word_t    na, db, dc;
    tis_pkg::tis_geo_t geo_next;
    tis_pkg::word_t    r0_next, r1_next;
    logic [RATIO_BITS:0] q0_next, q1_next;

    always_comb
    begin
        val[0] = item.value_0;
        val[1] = item.value_1;
        val[2] = item.value_2;
        pos[0][0] = item.x_0; pos[0][1] = item.y_0; pos[0][2] = item.z_0;
        pos[1][0] = item.x_1; pos[1][1] = item.y_1; pos[1][2] = item.z_1;
        pos[2][0] = item.x_2; pos[2][1] = item.y_2; pos[2][2] = item.z_2;
        for (int k = 0; k < 3; k++)
        begin
            code[k] = $signed(val[k]) > $signed(iso_level);
        end
        a = tis_pkg::APEX_TAB[code];
        case (a)
            tis_pkg::VERTEX_0:
            begin
                b = tis_pkg::VERTEX_1; c = tis_pkg::VERTEX_2;
            end
            tis_pkg::VERTEX_1:
            begin
                b = tis_pkg::VERTEX_2; c = tis_pkg::VERTEX_0;
            end
            default:
            begin
                b = tis_pkg::VERTEX_0; c = tis_pkg::VERTEX_1;
            end
        endcase
        na = tis_pkg::abs_diff(iso_level, val[a]);
        db = tis_pkg::abs_diff(val[b], val[a]);
        dc = tis_pkg::abs_diff(val[c], val[a]);

        geo_next.present = tis_pkg::CROSSES_TAB[code];
        geo_next.apex    = a;
        for (int k = 0; k < 3; k++)
        begin
            geo_next.pa[k]    = pos[a][k];
            geo_next.mag_b[k] = tis_pkg::abs_diff(pos[a][k], pos[b][k]);
            geo_next.dir_b[k] = $signed(pos[b][k]) > $signed(pos[a][k]);
            geo_next.mag_c[k] = tis_pkg::abs_diff(pos[a][k], pos[c][k]);
            geo_next.dir_c[k] = $signed(pos[c][k]) > $signed(pos[a][k]);
        end

        // ratio of one saturates: start the quotient at 1, it shifts up to 2^R
        if (na >= db)
        begin
            r0_next = '0;
            q0_next = (RATIO_BITS+1)'(1);
        end
        else
        begin
            r0_next = na;
            q0_next = '0;
        end
        if (na >= dc)
        begin
            r1_next = '0;
            q1_next = (RATIO_BITS+1)'(1);
        end
        else
        begin
            r1_next = na;
            q1_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg <= geo_next;
            r0_reg  <= r0_next;
            d0_reg  <= db;
            q0_reg  <= q0_next;
            r1_reg  <= r1_next;
            d1_reg  <= dc;
            q1_reg  <= q1_next;
        end
    end

endmodule

// File: hw/rtl/tis_div_stage.sv
module tis_div_stage #(
    parameter int RATIO_BITS = tis_pkg::RATIO_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid,
    input  tis_pkg::tis_geo_t     geo,
    input  tis_pkg::word_t        r0,
    input  tis_pkg::word_t        d0,
    input  logic [RATIO_BITS:0]   q0,
    input  tis_pkg::word_t        r1,
    input  tis_pkg::word_t        d1,
    input  logic [RATIO_BITS:0]   q1,
    output logic                  valid_reg,
    output tis_pkg::tis_geo_t     geo_reg,
    output tis_pkg::word_t        r0_reg,
    output tis_pkg::word_t        d0_reg,
    output logic [RATIO_BITS:0]   q0_reg,
    output tis_pkg::word_t        r1_reg,
    output tis_pkg::word_t        d1_reg,
    output logic [RATIO_BITS:0]   q1_reg
);

    localparam int W = tis_pkg::VALUE_WIDTH;

    logic [W:0]          rem0, rem1, sub0, sub1;
    tis_pkg::word_t      r0_next, r1_next;
    logic [RATIO_BITS:0] q0_next, q1_next;

    // one restoring step per ratio
    always_comb
    begin
        rem0 = {r0, 1'b0};
        sub0 = rem0 - {1'b0, d0};
        if (rem0 >= {1'b0, d0})
        begin
            r0_next = sub0[W-1:0];
            q0_next = {q0[RATIO_BITS-1:0], 1'b1};
        end
        else
        begin
            r0_next = rem0[W-1:0];
            q0_next = {q0[RATIO_BITS-1:0], 1'b0};
        end
        rem1 = {r1, 1'b0};
        sub1 = rem1 - {1'b0, d1};
        if (rem1 >= {1'b0, d1})
        begin
            r1_next = sub1[W-1:0];
            q1_next = {q1[RATIO_BITS-1:0], 1'b1};
        end
        else
        begin
            r1_next = rem1[W-1:0];
            q1_next = {q1[RATIO_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg <= geo;
            r0_reg  <= r0_next;
            d0_reg  <= d0;
            q0_reg  <= q0_next;
            r1_reg  <= r1_next;
            d1_reg  <= d1;
            q1_reg  <= q1_next;
        end
    end

endmodule

// File: hw/rtl/tis_lerp.sv
module tis_lerp #(
    parameter int RATIO_BITS = tis_pkg::RATIO_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid,
    input  tis_pkg::tis_geo_t     geo,
    input  logic [RATIO_BITS:0]   q0,
    input  logic [RATIO_BITS:0]   q1,
    output logic                  valid_reg,
    output tis_pkg::tis_out_t     item_reg
);

    localparam int W = tis_pkg::VALUE_WIDTH;
    localparam int PW = W + RATIO_BITS + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (RATIO_BITS - 1);

    logic [5:0][PW-1:0] prod_next, prod_reg;
    tis_pkg::tis_geo_t  geo_m_reg;
    logic               valid_m_reg;
    logic [PW-1:0]      rounded [6];
    tis_pkg::word_t     pt [6];
    tis_pkg::tis_out_t  item_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k]     = PW'(geo.mag_b[k]) * PW'(q0);
            prod_next[k + 3] = PW'(geo.mag_c[k]) * PW'(q1);
        end
    end

    // round half up on the magnitude, then step away from the apex
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            rounded[k] = (prod_reg[k] + HALF) >> RATIO_BITS;
        end
        for (int k = 0; k < 3; k++)
        begin
            pt[k] = geo_m_reg.dir_b[k] ? geo_m_reg.pa[k] + rounded[k][W-1:0]
                                       : geo_m_reg.pa[k] - rounded[k][W-1:0];
            pt[k + 3] = geo_m_reg.dir_c[k] ? geo_m_reg.pa[k] + rounded[k + 3][W-1:0]
                                           : geo_m_reg.pa[k] - rounded[k + 3][W-1:0];
        end
        if (geo_m_reg.present)
        begin
            item_next.segment_present = 1'b1;
            item_next.apex_vertex     = geo_m_reg.apex;
            item_next.start_x         = pt[0];
            item_next.start_y         = pt[1];
            item_next.start_z         = pt[2];
            item_next.end_x           = pt[3];
            item_next.end_y           = pt[4];
            item_next.end_z           = pt[5];
        end
        else
        begin
            item_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            valid_m_reg <= valid;
            valid_reg   <= valid_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            geo_m_reg <= geo;
            item_reg  <= item_next;
        end
    end

endmodule

// File: hw/rtl/triangle_isoline_segment_core.sv
// Marching-triangles isoline segment core.
// Input channel (in_valid / in_stall / in_item): one triangle per item, three
// vertex values and three positions, signed Q16.16.
// Output channel (out_valid / out_stall / out_item): one segment per item, with
// segment_present low and all other fields zero when the level misses it.
// Configuration (cfg_valid / cfg_ready / cfg_data): the iso level, always ready;
// write it only while the pipeline is empty.
// The pipeline has one classify stage, one restoring division step per ratio
// bit, a multiply stage and a round/offset stage that is also the output
// register. Throughput is one item per cycle while the output is not stalled.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall is raised; nothing is dropped or repeated.
// Reset clears every valid bit and sets the iso level to zero.
module triangle_isoline_segment_core #(
    parameter int RATIO_BITS = tis_pkg::RATIO_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tis_pkg::tis_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output tis_pkg::tis_out_t out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  tis_pkg::word_t    cfg_data
);

    tis_pkg::word_t    iso_level_reg;
    logic              en;

    logic                v_s  [RATIO_BITS+1];
    tis_pkg::tis_geo_t   g_s  [RATIO_BITS+1];
    tis_pkg::word_t      r0_s [RATIO_BITS+1];
    tis_pkg::word_t      d0_s [RATIO_BITS+1];
    logic [RATIO_BITS:0] q0_s [RATIO_BITS+1];
    tis_pkg::word_t      r1_s [RATIO_BITS+1];
    tis_pkg::word_t      d1_s [RATIO_BITS+1];
    logic [RATIO_BITS:0] q1_s [RATIO_BITS+1];

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_level_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            iso_level_reg <= cfg_data;
        end
    end

    tis_classify #(.RATIO_BITS(RATIO_BITS)) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (in_valid),
        .item      (in_item),
        .iso_level (iso_level_reg),
        .valid_reg (v_s[0]),
        .geo_reg   (g_s[0]),
        .r0_reg    (r0_s[0]),
        .d0_reg    (d0_s[0]),
        .q0_reg    (q0_s[0]),
        .r1_reg    (r1_s[0]),
        .d1_reg    (d1_s[0]),
        .q1_reg    (q1_s[0])
    );

    for (genvar i = 0; i < RATIO_BITS; i++)
    begin : g_div
        tis_div_stage #(.RATIO_BITS(RATIO_BITS)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (v_s[i]),
            .geo       (g_s[i]),
            .r0        (r0_s[i]),
            .d0        (d0_s[i]),
            .q0        (q0_s[i]),
            .r1        (r1_s[i]),
            .d1        (d1_s[i]),
            .q1        (q1_s[i]),
            .valid_reg (v_s[i+1]),
            .geo_reg   (g_s[i+1]),
            .r0_reg    (r0_s[i+1]),
            .d0_reg    (d0_s[i+1]),
            .q0_reg    (q0_s[i+1]),
            .r1_reg    (r1_s[i+1]),
            .d1_reg    (d1_s[i+1]),
            .q1_reg    (q1_s[i+1])
        );
    end

    tis_lerp #(.RATIO_BITS(RATIO_BITS)) u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v_s[RATIO_BITS]),
        .geo       (g_s[RATIO_BITS]),
        .q0        (q0_s[RATIO_BITS]),
        .q1        (q1_s[RATIO_BITS]),
        .valid_reg (out_valid),
        .item_reg  (out_item)
    );

endmodule

// File: hw/rtl/tis_checker.sv
module tis_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input tis_pkg::tis_out_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled output item changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.segment_present |->
            out_item.apex_vertex == tis_pkg::VERTEX_0 && out_item.start_x == '0
            && out_item.end_z == '0)
        else $error("empty segment with non-zero fields");

    a_apex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.segment_present |->
            out_item.apex_vertex == tis_pkg::VERTEX_0
            || out_item.apex_vertex == tis_pkg::VERTEX_1
            || out_item.apex_vertex == tis_pkg::VERTEX_2)
        else $error("apex index out of range");

endmodule

bind triangle_isoline_segment_core tis_checker u_tis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// File: tb/sv/triangle_isoline_segment_core_tb.sv
`timescale 1ns / 100ps

module triangle_isoline_segment_core_tb;

    localparam int RBITS = tis_pkg::RATIO_BITS_DEFAULT;
    localparam int LATENCY = RBITS + 3;
    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_RANDOM = 500;
    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    tis_pkg::tis_in_t in_item;
    logic out_valid;
    logic out_stall;
    tis_pkg::tis_out_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    tis_pkg::word_t cfg_data;

    tis_pkg::word_t level;
    tis_pkg::tis_out_t segment_q[$];
    int errors;
    int idle_cycles;
    bit hold_long;
    bit stim_done;

    typedef struct {
        tis_pkg::tis_in_t tri_item;
        bit known;
        tis_pkg::tis_out_t want;
    } row_t;

    row_t rows[$];

    triangle_isoline_segment_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic tis_pkg::word_t abs_diff_tb(tis_pkg::word_t a, tis_pkg::word_t b);
        if ($signed(a) > $signed(b))
        begin
            return a - b;
        end
        return b - a;
    endfunction

    function automatic logic [63:0] edge_ratio(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        if (d == 0)
        begin
            return 0;
        end
        if (n >= d)
        begin
            return 64'd1 << RBITS;
        end
        q = (n << RBITS) / d;
        return q;
    endfunction

    function automatic tis_pkg::word_t edge_point(tis_pkg::word_t pa, tis_pkg::word_t pb,
                                                  logic [63:0] q);
        logic [63:0] mag;
        logic [63:0] off;
        mag = {32'd0, abs_diff_tb(pa, pb)};
        off = (mag * q + (64'd1 << (RBITS - 1))) >> RBITS;
        if (q >> RBITS)
        begin
            off = mag;
        end
        if ($signed(pb) > $signed(pa))
        begin
            return pa + off[31:0];
        end
        return pa - off[31:0];
    endfunction

    function automatic tis_pkg::tis_out_t predict_segment(tis_pkg::tis_in_t t,
                                                          tis_pkg::word_t iso);
        tis_pkg::tis_out_t r;
        tis_pkg::word_t v[3];
        tis_pkg::word_t p[3][3];
        logic [2:0] code;
        int a;
        int b;
        int c;
        logic [63:0] na;
        logic [63:0] q0;
        logic [63:0] q1;
        r = '0;
        v[0] = t.value_0;
        v[1] = t.value_1;
        v[2] = t.value_2;
        p[0][0] = t.x_0; p[0][1] = t.y_0; p[0][2] = t.z_0;
        p[1][0] = t.x_1; p[1][1] = t.y_1; p[1][2] = t.z_1;
        p[2][0] = t.x_2; p[2][1] = t.y_2; p[2][2] = t.z_2;
        for (int k = 0; k < 3; k++)
        begin
            code[k] = $signed(v[k]) > $signed(iso);
        end
        if (code == 3'b000 || code == 3'b111)
        begin
            return r;
        end
        // apex is the vertex alone on its side of the level
        if (code == 3'b001 || code == 3'b110)
        begin
            a = 0;
        end
        else if (code == 3'b010 || code == 3'b101)
        begin
            a = 1;
        end
        else
        begin
            a = 2;
        end
        b = (a + 1) % 3;
        c = (a + 2) % 3;
        na = {32'd0, abs_diff_tb(iso, v[a])};
        q0 = edge_ratio(na, {32'd0, abs_diff_tb(v[b], v[a])});
        q1 = edge_ratio(na, {32'd0, abs_diff_tb(v[c], v[a])});
        r.segment_present = 1'b1;
        r.apex_vertex = 2'(a);
        r.start_x = edge_point(p[a][0], p[b][0], q0);
        r.start_y = edge_point(p[a][1], p[b][1], q0);
        r.start_z = edge_point(p[a][2], p[b][2], q0);
        r.end_x = edge_point(p[a][0], p[c][0], q1);
        r.end_y = edge_point(p[a][1], p[c][1], q1);
        r.end_z = edge_point(p[a][2], p[c][2], q1);
        return r;
    endfunction

    function automatic tis_pkg::word_t rand_word();
        case ($urandom_range(0, 5))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic tis_pkg::tis_in_t rand_triangle(tis_pkg::word_t iso);
        tis_pkg::tis_in_t t;
        t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(0, 9) < 8)
        begin
            // mostly crossing triangles, values around the level
            t.value_0 = ($urandom_range(0, 1)) ? rand_word() : iso + $urandom_range(0, 4) - 2;
            t.value_1 = ($urandom_range(0, 1)) ? rand_word() : iso + $urandom_range(0, 4) - 2;
            t.value_2 = ($urandom_range(0, 1)) ? rand_word() : iso + $urandom_range(0, 4) - 2;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            t.x_0 = rand_word(); t.y_1 = rand_word(); t.z_2 = rand_word();
        end
        return t;
    endfunction

    task automatic write_level(tis_pkg::word_t w);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        level = w;
    endtask

    task automatic wait_drained();
        while (segment_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic send_triangle(tis_pkg::tis_in_t t, bit known, tis_pkg::tis_out_t want);
        in_valid <= 1'b1;
        in_item <= t;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        segment_q.push_back(known ? want : predict_segment(t, level));
    endtask

    task automatic add_row(tis_pkg::tis_in_t t, bit known, tis_pkg::tis_out_t want);
        row_t r;
        r.tri_item = t;
        r.known = known;
        r.want = want;
        rows.push_back(r);
    endtask

    // check results
    always @(posedge clk)
    begin
        tis_pkg::tis_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            idle_cycles = 0;
            if (segment_q.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                e = segment_q.pop_front();
                if (out_item.segment_present !== e.segment_present)
                begin
                    $error("segment_present exp %0d got %0d", e.segment_present,
                           out_item.segment_present);
                    errors++;
                end
                if (out_item.apex_vertex !== e.apex_vertex)
                begin
                    $error("apex_vertex exp %0d got %0d", e.apex_vertex, out_item.apex_vertex);
                    errors++;
                end
                if (out_item.start_x !== e.start_x)
                begin
                    $error("start_x exp %h got %h", e.start_x, out_item.start_x);
                    errors++;
                end
                if (out_item.start_y !== e.start_y)
                begin
                    $error("start_y exp %h got %h", e.start_y, out_item.start_y);
                    errors++;
                end
                if (out_item.start_z !== e.start_z)
                begin
                    $error("start_z exp %h got %h", e.start_z, out_item.start_z);
                    errors++;
                end
                if (out_item.end_x !== e.end_x)
                begin
                    $error("end_x exp %h got %h", e.end_x, out_item.end_x);
                    errors++;
                end
                if (out_item.end_y !== e.end_y)
                begin
                    $error("end_y exp %h got %h", e.end_y, out_item.end_y);
                    errors++;
                end
                if (out_item.end_z !== e.end_z)
                begin
                    $error("end_z exp %h got %h", e.end_z, out_item.end_z);
                    errors++;
                end
            end
        end
        else if (rst_n && in_valid && !in_stall)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("triangle_isoline_segment_core_tb NOT OK");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_long = 1'b0;
            end
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 40; i++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= (i % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        tis_pkg::tis_in_t t;
        tis_pkg::tis_out_t z;
        tis_pkg::tis_out_t w;
        int burst;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        level = '0;
        errors = 0;
        idle_cycles = 0;
        hold_long = 1'b0;
        stim_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        // no crossing: all below, all equal (strict compare), all above
        add_row('0, 1, z);
        t = '0; t.value_0 = MAX_POS; t.value_1 = MAX_POS; t.value_2 = MAX_POS;
        add_row(t, 1, z);
        t = '0; t.value_0 = MAX_NEG; t.value_1 = MAX_NEG; t.value_2 = MAX_NEG;
        add_row(t, 1, z);
        // apex 0 alone above, ratio one half on both edges
        t = '0; t.value_0 = ONE; t.value_1 = -ONE; t.value_2 = -ONE;
        t.x_1 = 32'h0002_0000; t.y_2 = 32'h0002_0000;
        w = '0; w.segment_present = 1; w.apex_vertex = tis_pkg::VERTEX_0;
        w.start_x = ONE; w.end_y = ONE;
        add_row(t, 1, w);
        // every crossing code, extreme values and positions
        for (int code = 1; code < 7; code++)
        begin
            t = {12{MAX_NEG}};
            t.value_0 = code[0] ? MAX_POS : MAX_NEG;
            t.value_1 = code[1] ? MAX_POS : MAX_NEG;
            t.value_2 = code[2] ? MAX_POS : MAX_NEG;
            t.x_1 = MAX_POS; t.y_2 = MAX_POS; t.z_0 = MAX_POS;
            add_row(t, 0, z);
            t.value_0 = code[0] ? ONE : 0;
            t.value_1 = code[1] ? 1 : 32'hffff_ffff;
            t.value_2 = code[2] ? MAX_POS : 0;
            add_row(t, 0, z);
        end
        // apex value on the level gives ratio zero; far value on level is impossible
        t = '0; t.value_0 = 0; t.value_1 = ONE; t.value_2 = 7;
        t.x_1 = MAX_NEG; t.x_2 = MAX_POS;
        add_row(t, 0, z);

        foreach (rows[i])
        begin
            send_triangle(rows[i].tri_item, rows[i].known, rows[i].want);
        end
        in_valid <= 1'b0;
        wait_drained();

        // phases over iso levels, extremes among them
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_level(MAX_POS);
                1: write_level(MAX_NEG);
                2: write_level(-ONE);
                3: write_level(32'h0000_8000);
                default: write_level($urandom());
            endcase
            for (int n = 0; n < NUM_RANDOM / 5; )
            begin
                if (ph == 2 && n == 20)
                begin
                    hold_long = 1'b1;
                end
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < NUM_RANDOM / 5; b++, n++)
                begin
                    send_triangle(rand_triangle(level), 0, z);
                end
                // valid only drops when a gap follows
                if (ph == 1 && n > 40 && n < 60)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                else if ($urandom_range(0, 2) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("triangle_isoline_segment_core_tb OK");
        end
        else
        begin
            $display("triangle_isoline_segment_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tis_pkg.sv
hw/rtl/tis_classify.sv
hw/rtl/tis_div_stage.sv
hw/rtl/tis_lerp.sv
hw/rtl/triangle_isoline_segment_core.sv
hw/rtl/tis_checker.sv
tb/sv/triangle_isoline_segment_core_tb.sv
